FILE: sv/mmtb_pkg.sv
// Shared types, constants and helpers for the transposed-B integer matrix product.
`timescale 1ns / 1ps
package mmtb_pkg;

  localparam int MAX_DIM    = 16;
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [1:0] KIND_WRITE_A = 2'd0;
  localparam logic [1:0] KIND_WRITE_B = 2'd1;
  localparam logic [1:0] KIND_QUERY   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_N = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_O  = 2'd2;

  typedef struct packed {
    logic [1:0]               kind;
    logic [3:0]               row;
    logic [3:0]               col;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] product_value;
    logic [3:0]               out_row;
    logic [3:0]               out_col;
    logic                     range_error;
  } out_word_t;

  typedef struct packed {
    logic clear;
    logic operand_valid;
  } mac_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Clamp a size register to the range 1..MAX_DIM.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
    logic [DIM_W-1:0] d;
    if (r == '0) begin
      d = DIM_W'(1);
    end else if (r > DIM_W'(MAX_DIM)) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = r;
    end
    return d;
  endfunction

endpackage

FILE: sv/int32_matmul_transposed_b.sv
// Top level of the signed 32-bit matrix product C = A * transpose(B).
//
// Input words carry a kind, a row, a column and a value. Kind write-A or
// write-B stores the value at (row, col) of A or of B (B held by its rows)
// and gives no result. Kind query starts a dot product of A row 'row' with
// B row 'col' over inner_n terms; the other kind is dropped. A query walks
// the inner dimension through the shared multiply-accumulate unit, one term
// a cycle off the two store read ports; each term passes the store read
// register, the product register and the accumulator. An out-of-range
// query skips the walk and returns zero with range_error set. in_stall is
// high while a query is in work, while a write or a dropped word leaves
// the input free. One result register sits on the output: the next query
// runs while a result waits, and holds in its final step only while
// out_stall keeps that register full. The config port (rows_m, inner_n,
// cols_o at indexes 0..2) is to be written by the user only while the
// block is idle; the block does not enforce this. Reset returns the
// sequencer to idle, empties the output and sets all sizes to 16; store
// contents are undefined until written.
`timescale 1ns / 1ps
module int32_matmul_transposed_b (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mmtb_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mmtb_pkg::out_word_t               out_data,
  input  logic                              cfg_we,
  input  logic [mmtb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mmtb_pkg::DIM_W-1:0]        cfg_data
);

  logic                          a_we, b_we, mac_busy;
  logic [mmtb_pkg::ADDR_W-1:0]   waddr, a_raddr, b_raddr;
  logic [mmtb_pkg::DATA_W-1:0]   wdata, a_rdata, b_rdata, acc;
  mmtb_pkg::mac_ctl_t            mac_ctl;

  mmtb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .a_we      (a_we),
    .b_we      (b_we),
    .waddr     (waddr),
    .wdata     (wdata),
    .a_raddr   (a_raddr),
    .b_raddr   (b_raddr),
    .mac_ctl   (mac_ctl),
    .acc       (acc),
    .mac_busy  (mac_busy)
  );

  mmtb_store u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mmtb_store u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  mmtb_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .a_data (a_rdata),
    .b_data (b_rdata),
    .acc    (acc),
    .busy   (mac_busy)
  );

endmodule

FILE: sv/mmtb_store.sv
// Element store: one write port, one registered read port.
`timescale 1ns / 1ps
module mmtb_store (
  input  logic                          clk,
  input  logic                          we,
  input  logic [mmtb_pkg::ADDR_W-1:0]   waddr,
  input  logic [mmtb_pkg::DATA_W-1:0]   wdata,
  input  logic [mmtb_pkg::ADDR_W-1:0]   raddr,
  output logic [mmtb_pkg::DATA_W-1:0]   rdata
);

  logic [mmtb_pkg::DATA_W-1:0] mem [mmtb_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/mmtb_mac.sv
// Shared multiply-accumulate unit: registered product, then wrapping accumulate.
`timescale 1ns / 1ps
module mmtb_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  mmtb_pkg::mac_ctl_t            ctl,
  input  logic [mmtb_pkg::DATA_W-1:0]   a_data,
  input  logic [mmtb_pkg::DATA_W-1:0]   b_data,
  output logic [mmtb_pkg::DATA_W-1:0]   acc,
  output logic                          busy
);

  logic [mmtb_pkg::DATA_W-1:0] prod;
  logic                        prod_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.operand_valid;
    end
  end

  // Low 32 bits of the product are the same for signed and unsigned operands.
  always_ff @(posedge clk) begin
    prod <= a_data * b_data;
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + prod;
    end
  end

  assign busy = prod_valid;

endmodule

FILE: sv/mmtb_ctrl.sv
// Sequencer: config registers, store writes, dot-product walk and output register.
`timescale 1ns / 1ps
module mmtb_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mmtb_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mmtb_pkg::out_word_t               out_data,
  input  logic                              cfg_we,
  input  logic [mmtb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mmtb_pkg::DIM_W-1:0]        cfg_data,
  output logic                              a_we,
  output logic                              b_we,
  output logic [mmtb_pkg::ADDR_W-1:0]       waddr,
  output logic [mmtb_pkg::DATA_W-1:0]       wdata,
  output logic [mmtb_pkg::ADDR_W-1:0]       a_raddr,
  output logic [mmtb_pkg::ADDR_W-1:0]       b_raddr,
  output mmtb_pkg::mac_ctl_t                mac_ctl,
  input  logic [mmtb_pkg::DATA_W-1:0]       acc,
  input  logic                              mac_busy
);

  mmtb_pkg::state_t state, state_next;

  logic [mmtb_pkg::DIM_W-1:0] rows_m, inner_n, cols_o;
  logic [mmtb_pkg::DIM_W-1:0] dim_m, dim_n, dim_o;
  logic [mmtb_pkg::IDX_W-1:0] q_row, q_col, step, last_step;
  logic                       q_bad;
  logic                       rd_valid;
  logic                       accept, is_query, bad_now, issue, load;

  assign dim_m = mmtb_pkg::eff_dim(rows_m);
  assign dim_n = mmtb_pkg::eff_dim(inner_n);
  assign dim_o = mmtb_pkg::eff_dim(cols_o);

  assign accept   = in_valid && !in_stall;
  assign is_query = (in_data.kind == mmtb_pkg::KIND_QUERY);
  assign bad_now  = ({1'b0, in_data.row} >= dim_m) || ({1'b0, in_data.col} >= dim_o);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m  <= mmtb_pkg::DIM_W'(mmtb_pkg::MAX_DIM);
      inner_n <= mmtb_pkg::DIM_W'(mmtb_pkg::MAX_DIM);
      cols_o  <= mmtb_pkg::DIM_W'(mmtb_pkg::MAX_DIM);
    end else if (cfg_we) begin
      case (cfg_index)
        mmtb_pkg::CFG_ROWS_M:  rows_m  <= cfg_data;
        mmtb_pkg::CFG_INNER_N: inner_n <= cfg_data;
        mmtb_pkg::CFG_COLS_O:  cols_o  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mmtb_pkg::ST_IDLE: begin
        if (accept && is_query) begin
          state_next = bad_now ? mmtb_pkg::ST_FINISH : mmtb_pkg::ST_RUN;
        end
      end
      mmtb_pkg::ST_RUN: begin
        if (step == last_step) begin
          state_next = mmtb_pkg::ST_DRAIN;
        end
      end
      mmtb_pkg::ST_DRAIN: begin
        if (!rd_valid && !mac_busy) begin
          state_next = mmtb_pkg::ST_FINISH;
        end
      end
      mmtb_pkg::ST_FINISH: begin
        if (load) begin
          state_next = mmtb_pkg::ST_IDLE;
        end
      end
      default: state_next = mmtb_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    load     = 1'b0;
    case (state)
      mmtb_pkg::ST_IDLE:   in_stall = 1'b0;
      mmtb_pkg::ST_RUN:    issue = 1'b1;
      mmtb_pkg::ST_DRAIN:  ;
      mmtb_pkg::ST_FINISH: load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  assign a_we    = accept && (in_data.kind == mmtb_pkg::KIND_WRITE_A);
  assign b_we    = accept && (in_data.kind == mmtb_pkg::KIND_WRITE_B);
  assign waddr   = {in_data.row, in_data.col};
  assign wdata   = in_data.value;
  assign a_raddr = {q_row, step};
  assign b_raddr = {q_col, step};

  assign mac_ctl.clear         = accept && is_query;
  assign mac_ctl.operand_valid = rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mmtb_pkg::ST_IDLE;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      q_row     <= in_data.row;
      q_col     <= in_data.col;
      q_bad     <= bad_now;
      step      <= '0;
      last_step <= mmtb_pkg::IDX_W'(dim_n - mmtb_pkg::DIM_W'(1));
    end else if (issue) begin
      step <= step + mmtb_pkg::IDX_W'(1);
    end
    if (load) begin
      out_data.product_value <= q_bad ? '0 : acc;
      out_data.out_row       <= q_row;
      out_data.out_col       <= q_col;
      out_data.range_error   <= q_bad;
    end
  end

endmodule

FILE: dv/int32_matmul_transposed_b_tb.sv
// Self-checking testbench for the transposed-B int32 matrix product block.
`timescale 1ns / 1ps
module int32_matmul_transposed_b_tb;

  localparam int TARGET_WORDS   = 1100;
  localparam int PHASE_WORDS    = 120;
  localparam int SETTLE_CYCLES  = 30;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  localparam logic [1:0]                     KIND_UNUSED = 2'd3;
  localparam logic [mmtb_pkg::CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  // Expected products of A * transpose(B), kept in query order.
  class product_scoreboard;
    logic [mmtb_pkg::DATA_W-1:0] a_mem [mmtb_pkg::DEPTH];
    logic [mmtb_pkg::DATA_W-1:0] b_mem [mmtb_pkg::DEPTH];
    logic [mmtb_pkg::DIM_W-1:0]  rows_reg, inner_reg, cols_reg;
    mmtb_pkg::out_word_t         due_results [$];
    int                          errors, results, queries, range_errs, writes, dropped;

    function new();
      foreach (a_mem[i]) begin
        a_mem[i] = '0;
        b_mem[i] = '0;
      end
      rows_reg  = mmtb_pkg::DIM_W'(16);
      inner_reg = mmtb_pkg::DIM_W'(16);
      cols_reg  = mmtb_pkg::DIM_W'(16);
    endfunction

    function int eff_size(logic [mmtb_pkg::DIM_W-1:0] r);
      if (r == '0) return 1;
      if (r > mmtb_pkg::MAX_DIM) return mmtb_pkg::MAX_DIM;
      return int'(r);
    endfunction

    function void write_size(logic [mmtb_pkg::CFG_IDX_W-1:0] idx,
                             logic [mmtb_pkg::DIM_W-1:0] v);
      case (idx)
        mmtb_pkg::CFG_ROWS_M:  rows_reg  = v;
        mmtb_pkg::CFG_INNER_N: inner_reg = v;
        mmtb_pkg::CFG_COLS_O:  cols_reg  = v;
        default: ;
      endcase
    endfunction

    function logic [mmtb_pkg::DATA_W-1:0] dot_value(logic [3:0] r, logic [3:0] c);
      logic [mmtb_pkg::DATA_W-1:0] acc;
      int n;
      n = eff_size(inner_reg);
      acc = '0;
      for (int j = 0; j < n; j++) begin
        acc = acc + a_mem[{r, 4'(j)}] * b_mem[{c, 4'(j)}];
      end
      return acc;
    endfunction

    function void note_word(mmtb_pkg::in_word_t w);
      mmtb_pkg::out_word_t e;
      case (w.kind)
        mmtb_pkg::KIND_WRITE_A: begin
          a_mem[{w.row, w.col}] = w.value;
          writes++;
        end
        mmtb_pkg::KIND_WRITE_B: begin
          b_mem[{w.row, w.col}] = w.value;
          writes++;
        end
        mmtb_pkg::KIND_QUERY: begin
          e.out_row       = w.row;
          e.out_col       = w.col;
          e.range_error   = (w.row >= eff_size(rows_reg)) || (w.col >= eff_size(cols_reg));
          e.product_value = e.range_error ? '0 : dot_value(w.row, w.col);
          due_results.push_back(e);
          queries++;
          if (e.range_error) range_errs++;
        end
        default: dropped++;
      endcase
    endfunction

    function void check_word(mmtb_pkg::out_word_t got);
      mmtb_pkg::out_word_t e;
      if (due_results.size() == 0) begin
        if (errors < 10)
          $display("ERROR: result with no query waiting: (%0d,%0d) value %0d err %0b",
                   got.out_row, got.out_col, got.product_value, got.range_error);
        errors++;
      end else begin
        e = due_results.pop_front();
        results++;
        if (got.product_value !== e.product_value || got.out_row !== e.out_row ||
            got.out_col !== e.out_col || got.range_error !== e.range_error) begin
          if (errors < 10)
            $display({"ERROR: expected (%0d,%0d) value %0d err %0b,",
                      " got (%0d,%0d) value %0d err %0b"},
                     e.out_row, e.out_col, e.product_value, e.range_error,
                     got.out_row, got.out_col, got.product_value, got.range_error);
          errors++;
        end
      end
    endfunction
  endclass

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           in_valid  = 1'b0;
  mmtb_pkg::in_word_t             in_data   = '0;
  logic                           out_stall = 1'b0;
  logic                           cfg_we    = 1'b0;
  logic [mmtb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mmtb_pkg::DIM_W-1:0]     cfg_data  = '0;
  logic                           in_stall;
  logic                           out_valid;
  mmtb_pkg::out_word_t            out_data;

  product_scoreboard sb;
  int  sent_words;
  int  phase;
  bit  burst_mode;
  bit  hold_req;
  bit  a_set [mmtb_pkg::DEPTH];
  bit  b_set [mmtb_pkg::DEPTH];

  int m_tab [8] = '{16, 1, 0, 31, 17, 4, 9, 16};
  int n_tab [8] = '{16, 1, 0, 31, 3, 16, 7, 2};
  int o_tab [8] = '{16, 1, 0, 31, 2, 12, 16, 5};

  int32_matmul_transposed_b dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_size(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_word(in_data);
      if (out_valid && !out_stall) sb.check_word(out_data);
    end
  end

  // Output side: random stalls, plus one long hold when asked.
  initial begin
    int len;
    int pick;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 20);
        end else if (pick < 55) begin
          out_stall <= 1'b0;
          len = $urandom_range(60, 150);
        end else if (pick < 88) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else if (pick < 97) begin
          out_stall <= 1'b1;
          len = $urandom_range(4, 15);
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(30, 80);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("int32_matmul_transposed_b regression: fail");
    $finish;
  end

  function automatic logic [mmtb_pkg::DATA_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      4: return 32'($urandom_range(0, 7));
      5: return 32'hffff_fff8 | 32'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  // Offer one word, hold it until taken, then, outside burst mode, idle for a random gap that may be zero.
  task automatic push_word(logic [1:0] kind, logic [3:0] r, logic [3:0] c,
                           logic [mmtb_pkg::DATA_W-1:0] v);
    mmtb_pkg::in_word_t w;
    int g;
    int pick;
    w.kind  = kind;
    w.row   = r;
    w.col   = c;
    w.value = v;
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent_words++;
    if (kind == mmtb_pkg::KIND_WRITE_A) a_set[{r, c}] = 1'b1;
    if (kind == mmtb_pkg::KIND_WRITE_B) b_set[{r, c}] = 1'b1;
    g = 0;
    if (!burst_mode) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) g = 0;
      else if (pick < 90) g = $urandom_range(1, 3);
      else if (pick < 98) g = $urandom_range(4, 12);
      else g = $urandom_range(20, 40);
    end
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    // let the monitor note the last accepted word first
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
    // writes give no result; let any last one retire
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_sizes(int m, int n, int o, bit spare);
    cfg_we    <= 1'b1;
    cfg_index <= mmtb_pkg::CFG_ROWS_M;
    cfg_data  <= mmtb_pkg::DIM_W'(m);
    @(posedge clk);
    cfg_index <= mmtb_pkg::CFG_INNER_N;
    cfg_data  <= mmtb_pkg::DIM_W'(n);
    @(posedge clk);
    cfg_index <= mmtb_pkg::CFG_COLS_O;
    cfg_data  <= mmtb_pkg::DIM_W'(o);
    @(posedge clk);
    if (spare) begin
      cfg_index <= CFG_UNUSED;
      cfg_data  <= '1;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    // the scoreboard takes the last write at that edge; read it afterwards
    @(posedge clk);
  endtask

  // Load any operand a query of (r, c) would read but that was never written.
  task automatic fill_operands(logic [3:0] r, logic [3:0] c);
    int n;
    n = sb.eff_size(sb.inner_reg);
    for (int j = 0; j < n; j++) begin
      if (!a_set[{r, 4'(j)}]) push_word(mmtb_pkg::KIND_WRITE_A, r, 4'(j), rand_value());
      if (!b_set[{c, 4'(j)}]) push_word(mmtb_pkg::KIND_WRITE_B, c, 4'(j), rand_value());
    end
  endtask

  task automatic random_query();
    int m;
    int o;
    logic [3:0] r;
    logic [3:0] c;
    m = sb.eff_size(sb.rows_reg);
    o = sb.eff_size(sb.cols_reg);
    r = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, m - 1));
    c = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, o - 1));
    if (r < m && c < o) fill_operands(r, c);
    push_word(mmtb_pkg::KIND_QUERY, r, c, $urandom);
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)
      random_query();
    else if (pick < 95)
      push_word(pick[0] ? mmtb_pkg::KIND_WRITE_B : mmtb_pkg::KIND_WRITE_A,
                4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), rand_value());
    else
      push_word(KIND_UNUSED, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), $urandom);
  endtask

  // Fill the block while the output is held, so the input backs up.
  task automatic hold_burst();
    logic [3:0] qr [$];
    logic [3:0] qc [$];
    logic [3:0] r;
    logic [3:0] c;
    for (int k = 0; k < 24; k++) begin
      r = 4'($urandom_range(0, sb.eff_size(sb.rows_reg) - 1));
      c = 4'($urandom_range(0, sb.eff_size(sb.cols_reg) - 1));
      fill_operands(r, c);
      qr.push_back(r);
      qc.push_back(c);
    end
    burst_mode = 1'b1;
    hold_req   = 1'b1;
    foreach (qr[k]) push_word(mmtb_pkg::KIND_QUERY, qr[k], qc[k], $urandom);
    burst_mode = 1'b0;
  endtask

  initial begin
    int quota;
    sb = new();
    sent_words = 0;
    burst_mode = 1'b0;
    hold_req   = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // extreme values and corner coordinates, short dot products
    set_sizes(16, 2, 16, 1'b0);
    push_word(mmtb_pkg::KIND_WRITE_A, 4'd15, 4'd0, 32'h8000_0000);
    push_word(mmtb_pkg::KIND_WRITE_A, 4'd15, 4'd1, 32'h7fff_ffff);
    push_word(mmtb_pkg::KIND_WRITE_B, 4'd15, 4'd0, 32'h8000_0000);
    push_word(mmtb_pkg::KIND_WRITE_B, 4'd15, 4'd1, 32'hffff_ffff);
    push_word(mmtb_pkg::KIND_QUERY,   4'd15, 4'd15, 32'h0);
    push_word(mmtb_pkg::KIND_WRITE_A, 4'd0, 4'd0, 32'hffff_ffff);
    push_word(mmtb_pkg::KIND_WRITE_A, 4'd0, 4'd1, 32'h7fff_ffff);
    push_word(mmtb_pkg::KIND_WRITE_B, 4'd0, 4'd0, 32'hffff_ffff);
    push_word(mmtb_pkg::KIND_WRITE_B, 4'd0, 4'd1, 32'h7fff_ffff);
    push_word(mmtb_pkg::KIND_QUERY,   4'd0, 4'd0, 32'hffff_ffff);
    push_word(mmtb_pkg::KIND_QUERY,   4'd0, 4'd15, 32'h8000_0000);
    push_word(mmtb_pkg::KIND_QUERY,   4'd15, 4'd0, 32'h7fff_ffff);
    push_word(KIND_UNUSED,            4'd15, 4'd15, 32'hffff_ffff);
    push_word(KIND_UNUSED,            4'd0, 4'd0, 32'h0);
    drain();

    // zero and over-range sizes clamp; spare index is dropped
    set_sizes(0, 0, 17, 1'b1);
    push_word(mmtb_pkg::KIND_QUERY,   4'd1, 4'd0, 32'h0);
    push_word(mmtb_pkg::KIND_QUERY,   4'd0, 4'd15, 32'h0);
    push_word(mmtb_pkg::KIND_QUERY,   4'd15, 4'd15, 32'h0);
    push_word(mmtb_pkg::KIND_WRITE_A, 4'd9, 4'd9, 32'h7fff_ffff);
    push_word(mmtb_pkg::KIND_QUERY,   4'd0, 4'd0, 32'h0);
    drain();
    set_sizes(31, 31, 0, 1'b0);
    push_word(mmtb_pkg::KIND_QUERY,   4'd0, 4'd1, 32'h0);
    push_word(mmtb_pkg::KIND_QUERY,   4'd15, 4'd5, 32'h0);
    drain();

    phase = 0;
    while (sent_words < TARGET_WORDS) begin
      if (phase < 8)
        set_sizes(m_tab[phase], n_tab[phase], o_tab[phase], 1'b0);
      else
        set_sizes($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31), 1'b0);
      burst_mode = (phase % 4 == 3);
      if (phase == 5) hold_burst();
      quota = sent_words + PHASE_WORDS;
      while (sent_words < quota) random_item();
      burst_mode = 1'b0;
      drain();
      phase++;
    end

    $display("checked %0d results from %0d input words: %0d writes, %0d queries",
             sb.results, sent_words, sb.writes, sb.queries);
    $display("%0d out of range, %0d dropped, %0d size settings, one %0d-cycle output hold",
             sb.range_errs, sb.dropped, phase + 3, HOLD_CYCLES);
    if (sb.errors == 0 && sb.due_results.size() == 0)
      $display("int32_matmul_transposed_b regression: pass");
    else
      $display("int32_matmul_transposed_b regression: fail");
    $finish;
  end

endmodule
